@@ rtl/tpd_pkg.sv @@
// ---------------------------------------------------------------------------
// tpd_pkg: shared types and constants of the thermal propagation detector
// Incident entry and cell control types, register indexes and sample kinds.
// ---------------------------------------------------------------------------
`default_nettype none
package tpd_pkg;

   localparam int SENSORS_DEFAULT   = 8;
   localparam int INCIDENTS_DEFAULT = 16;
   localparam int KINDS             = 3;

   localparam logic [1:0] KIND_TEMPERATURE = 2'd0;
   localparam logic [1:0] KIND_VOLTAGE     = 2'd1;
   localparam logic [1:0] KIND_PRESSURE    = 2'd2;

   localparam logic [7:0] REG_TEMPERATURE_LIMIT = 8'd0;
   localparam logic [7:0] REG_VOLTAGE_LIMIT     = 8'd1;
   localparam logic [7:0] REG_PRESSURE_LIMIT    = 8'd2;
   localparam logic [7:0] REG_RELATED_WINDOW    = 8'd3;
   localparam logic [7:0] REG_NEIGHBOUR_MAP     = 8'd4;
   localparam logic [7:0] REG_PRESSURE_PRESENT  = 8'd5;

   typedef struct packed {
      logic [2:0]  sensor;
      logic [1:0]  kind;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic       shift;     // take the entry of the upper neighbour
      logic       search;    // evaluate the propagation match
      logic [7:0] row;       // neighbour row of the newest incident's sensor
      logic [1:0] kind;      // kind of the newest incident
      logic       pressure;  // a pressure incident is required in the pair
   } cell_ctrl_type;

endpackage
`default_nettype wire

@@ rtl/tpd_cell.sv @@
// ---------------------------------------------------------------------------
// tpd_cell: one place of the incident window
// Holds one incident, shifts towards the oldest end and flags a match.
// ---------------------------------------------------------------------------
`default_nettype none
module tpd_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tpd_pkg::cell_ctrl_type ctrl,
   input  wire logic                   live,
   input  wire logic                   load,
   input  wire tpd_pkg::entry_type     load_entry,
   input  wire tpd_pkg::entry_type     upper_entry,
   output tpd_pkg::entry_type          entry,
   output logic                        match
);
   import tpd_pkg::*;

   entry_type entry_ff, entry_in;
   logic      match_ff, match_in;
   logic      kind_ok;

   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in = load_entry;
      end else if (ctrl.shift) begin
         entry_in = upper_entry;
      end
   end

   // Pair rule: another kind, and with pressure sensors fitted one side is pressure.
   assign kind_ok = (entry_ff.kind != ctrl.kind) &&
                    (!ctrl.pressure || entry_ff.kind == KIND_PRESSURE ||
                     ctrl.kind == KIND_PRESSURE);

   always_comb begin
      match_in = match_ff;
      if (ctrl.search) begin
         match_in = live && ctrl.row[entry_ff.sensor] && kind_ok;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;
endmodule
`default_nettype wire

@@ rtl/thermal_propagation_detector_top.sv @@
// ---------------------------------------------------------------------------
// thermal_propagation_detector_top: rate incidents and propagation detection
// Tests each sample's rate of change, keeps incidents in a window of cells
// and flags propagation between neighbouring sensors of different kinds.
// ---------------------------------------------------------------------------
//   Channel  Direction  Beat contents
//   req_     in         one sample: sensor, kind (tuser), value, time
//   rsp_     out        one result: incident flag, propagation flag, time
//   csr_     in         one register write: index and data
//
// An item with an invalid kind or sensor goes from the difference state to
// the output state; a valid item that raises no incident passes difference,
// product and test; one that raises an incident also runs prune, search and
// reduce, and prune drops one stale incident per step, at most INCIDENTS-1. The
// result register frees the input side, so a new sample is accepted while an
// earlier result waits; a second result waits in the output state until the
// first beat has gone. Reset is synchronous and active high and clears all
// control state and the previous samples.
// ---------------------------------------------------------------------------
`default_nettype none
module thermal_propagation_detector_top #(
   parameter int SENSORS   = tpd_pkg::SENSORS_DEFAULT,
   parameter int INCIDENTS = tpd_pkg::INCIDENTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata from bit 0: sensor_number[2:0], sample_value[18:3], sample_time[50:19]
   input  wire logic [55:0] req_tdata,
   // tuser: sample_kind[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata from bit 0: incident_raised[0], propagation_found[1], detection_time[33:2]
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import tpd_pkg::*;

   localparam int SLOTS = SENSORS * KINDS;
   localparam int KW    = $clog2(SLOTS);
   localparam int CW    = $clog2(INCIDENTS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIFF   = 3'd1;
   localparam logic [2:0] ST_PROD   = 3'd2;
   localparam logic [2:0] ST_TEST   = 3'd3;
   localparam logic [2:0] ST_PRUNE  = 3'd4;
   localparam logic [2:0] ST_SEARCH = 3'd5;
   localparam logic [2:0] ST_REDUCE = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   // Configuration registers.
   logic [23:0] temp_limit_ff, volt_limit_ff, press_limit_ff;
   logic [31:0] window_ff;
   logic [63:0] map_ff;
   logic        pressure_ff;

   // Per sensor and kind history.
   logic [15:0] prev_sample_ff [SLOTS];
   logic [31:0] prev_time_ff   [SLOTS];

   logic [2:0]    state_ff, state_in;
   logic [2:0]    sensor_ff;
   logic [1:0]    kind_ff;
   logic [15:0]   value_ff;
   logic [31:0]   time_ff;
   logic [KW-1:0] slot_ff;
   logic          item_ok_ff;
   logic [24:0]   lhs_ff;
   logic [31:0]   dt_ff;
   logic          dt_pos_ff;
   logic [23:0]   limit_ff;
   logic [55:0]   prod_ff;
   logic          raised_ff, found_ff;
   logic [CW-1:0] count_ff;
   logic [31:0]   last_det_ff;
   logic          rsp_valid_ff;
   logic [39:0]   rsp_data_ff;

   logic          accept;
   logic          out_free;
   logic signed [16:0] dv;
   logic [16:0]   mag;
   logic [23:0]   limit_sel;
   logic          raised_now;
   logic          full;
   logic          store;
   logic          prune_step;
   logic          keep_oldest;
   logic [31:0]   age;
   logic          any_match;

   cell_ctrl_type ctrl;
   entry_type     new_entry;
   entry_type     cell_entry [INCIDENTS];
   logic [INCIDENTS-1:0] cell_match;
   logic [INCIDENTS-1:0] cell_load;
   logic [INCIDENTS-1:0] cell_live;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Configuration writes; an unknown index is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_limit_ff  <= 24'd256;
         volt_limit_ff  <= 24'd256;
         press_limit_ff <= 24'd256;
         window_ff      <= 32'd1000;
         map_ff         <= 64'd0;
         pressure_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TEMPERATURE_LIMIT: temp_limit_ff  <= csr_data[23:0];
            REG_VOLTAGE_LIMIT:     volt_limit_ff  <= csr_data[23:0];
            REG_PRESSURE_LIMIT:    press_limit_ff <= csr_data[23:0];
            REG_RELATED_WINDOW:    window_ff      <= csr_data[31:0];
            REG_NEIGHBOUR_MAP:     map_ff         <= csr_data;
            REG_PRESSURE_PRESENT:  pressure_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Rate arithmetic: the difference, then the product limit times dt.
   assign dv  = $signed({value_ff[15], value_ff}) -
                $signed({prev_sample_ff[slot_ff][15], prev_sample_ff[slot_ff]});
   assign mag = dv[16] ? 17'(-dv) : 17'(dv);

   always_comb begin
      case (kind_ff)
         KIND_TEMPERATURE: limit_sel = temp_limit_ff;
         KIND_VOLTAGE:     limit_sel = volt_limit_ff;
         default:          limit_sel = press_limit_ff;
      endcase
   end

   // Voltage needs a strict excess; a non-positive dt gives a zero rate.
   always_comb begin
      if (dt_pos_ff) begin
         raised_now = (kind_ff == KIND_VOLTAGE) ? (56'(lhs_ff) > prod_ff)
                                                : (56'(lhs_ff) >= prod_ff);
      end else begin
         raised_now = (kind_ff != KIND_VOLTAGE) && (limit_ff == 24'd0);
      end
   end

   // Window bookkeeping. Cell 0 holds the oldest incident; the newest is the
   // current sample, so its stamp, sensor and kind come from the item registers.
   assign full        = (count_ff == CW'(INCIDENTS));
   assign store       = (state_ff == ST_TEST) && raised_now;
   assign age         = time_ff - cell_entry[0].stamp;
   assign keep_oldest = (cell_entry[0].stamp > time_ff) || (age < window_ff);
   assign prune_step  = (state_ff == ST_PRUNE) && (count_ff > CW'(1)) && !keep_oldest;

   assign new_entry.sensor = sensor_ff;
   assign new_entry.kind   = kind_ff;
   assign new_entry.stamp  = time_ff;

   assign ctrl.shift    = (store && full) || prune_step;
   assign ctrl.search   = (state_ff == ST_SEARCH);
   assign ctrl.row      = map_ff[{sensor_ff, 3'b000} +: 8];
   assign ctrl.kind     = kind_ff;
   assign ctrl.pressure = pressure_ff;

   genvar j;
   generate
      for (j = 0; j < INCIDENTS; j++) begin : g_cell
         entry_type upper;
         if (j == INCIDENTS - 1) begin : g_end
            assign upper = cell_entry[j];
         end else begin : g_mid
            assign upper = cell_entry[j + 1];
         end
         assign cell_load[j] = store && (full ? (j == INCIDENTS - 1)
                                              : (count_ff == CW'(j)));
         assign cell_live[j] = (CW'(j) < count_ff);
         tpd_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .live        (cell_live[j]),
            .load        (cell_load[j]),
            .load_entry  (new_entry),
            .upper_entry (upper),
            .entry       (cell_entry[j]),
            .match       (cell_match[j])
         );
      end
   endgenerate

   assign any_match = |cell_match;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_DIFF;
         ST_DIFF:   state_in = item_ok_ff ? ST_PROD : ST_OUT;
         ST_PROD:   state_in = ST_TEST;
         ST_TEST:   state_in = raised_now ? ST_PRUNE : ST_OUT;
         ST_PRUNE:  if (!prune_step) state_in = ST_SEARCH;
         ST_SEARCH: state_in = ST_REDUCE;
         ST_REDUCE: state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         last_det_ff  <= 32'd0;
         raised_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            prev_sample_ff[i] <= 16'd0;
            prev_time_ff[i]   <= 32'd0;
         end
      end else begin
         state_ff <= state_in;
         // A new result beat replaces the one that leaves in the same cycle.
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               raised_ff <= 1'b0;
               found_ff  <= 1'b0;
            end
            ST_TEST: begin
               prev_sample_ff[slot_ff] <= value_ff;
               prev_time_ff[slot_ff]   <= time_ff;
               raised_ff               <= raised_now;
               if (store && !full) begin
                  count_ff <= count_ff + CW'(1);
               end
            end
            ST_PRUNE: begin
               if (prune_step) begin
                  count_ff <= count_ff - CW'(1);
               end
            end
            ST_REDUCE: begin
               found_ff <= any_match;
               if (any_match) begin
                  last_det_ff <= time_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         sensor_ff  <= req_tdata[2:0];
         kind_ff    <= req_tuser;
         value_ff   <= req_tdata[18:3];
         time_ff    <= req_tdata[50:19];
         slot_ff    <= KW'(int'(req_tdata[2:0]) * KINDS + int'(req_tuser));
         item_ok_ff <= (int'(req_tuser) < KINDS) && (int'(req_tdata[2:0]) < SENSORS);
      end
      if (state_ff == ST_DIFF) begin
         lhs_ff    <= {mag[16:0], 8'd0};
         dt_pos_ff <= time_ff > prev_time_ff[slot_ff];
         dt_ff     <= time_ff - prev_time_ff[slot_ff];
         limit_ff  <= limit_sel;
      end
      if (state_ff == ST_PROD) begin
         prod_ff <= limit_ff * dt_ff;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_data_ff <= {6'd0, last_det_ff, found_ff, raised_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
`default_nettype wire

@@ rtl/tpd_checker.sv @@
// ---------------------------------------------------------------------------
// tpd_checker: port level checks of the thermal propagation detector
// Watches the channels of the top level; attached by a bind statement.
// ---------------------------------------------------------------------------
`default_nettype none
module tpd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);
   // A result beat that is held back keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Propagation is only found on a sample that raised an incident.
   a_found_raised: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] || !rsp_tdata[1]))
      else $error("propagation without incident");

   // One sample at a time: the input side closes after a beat.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while busy");
endmodule

bind thermal_propagation_detector_top tpd_checker u_tpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the thermal propagation detector
// Directed and random samples are sent over the request stream. A
// behavioural model predicts every response beat, and the responses are
// compared field by field in order.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
   import tpd_pkg::*;

   localparam int NSENS = 8;
   localparam int NINC  = 16;
   localparam longint CYCLE_LIMIT = 400000;

   // A prediction for one response beat.
   typedef struct {
      bit        raised;
      bit        found;
      bit [31:0] dtime;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   thermal_propagation_detector_top dut (.*);

   always #5 clock = ~clock;

   // Copy of the configuration registers, mirrored on every register write.
   bit [23:0] lim_temp, lim_volt, lim_press;
   bit [31:0] window_ticks;
   bit [63:0] nbr_map;
   bit        press_required;

   // Per sensor and kind: the previous sample and its timestamp.
   bit [15:0] last_value [NSENS*3];
   bit [31:0] last_stamp [NSENS*3];

   // Ring of incidents, oldest at ring_head.
   bit [2:0]  ring_sensor [NINC];
   bit [1:0]  ring_kind   [NINC];
   bit [31:0] ring_stamp  [NINC];
   int        ring_count;
   int        ring_head;
   bit [31:0] held_detection;

   outcome_type pending_q[$];
   int        error_count = 0;
   longint    cycle_count = 0;
   bit        hold_off = 1'b0;
   bit        rand_stall = 1'b1;
   bit [31:0] clock_ticks;

   function automatic int ring_slot(int pos);
      return (ring_head + pos) % NINC;
   endfunction

   // Rate test: |dv|*256 against limit*dt, or 0 against limit when dt <= 0.
   function automatic bit rate_exceeded(bit [1:0] kind, int dv, longint dt);
      longint unsigned lim, lhs, rhs;
      lim = (kind == KIND_TEMPERATURE) ? lim_temp :
            (kind == KIND_VOLTAGE) ? lim_volt : lim_press;
      if (dt > 0) begin
         lhs = (dv < 0 ? -dv : dv) * 256;
         rhs = lim * dt;
      end else begin
         lhs = 0;
         rhs = lim;
      end
      return (kind == KIND_VOLTAGE) ? (lhs > rhs) : (lhs >= rhs);
   endfunction

   // Works out the response to one sample and advances the model state.
   function automatic outcome_type predict_response(bit [2:0] sensor, bit [1:0] kind,
                                                    bit [15:0] value, bit [31:0] stamp);
      outcome_type o;
      int k, s, drop, nw;
      int dv;
      longint dt, age;
      bit hit;
      o.raised = 0;
      o.found = 0;
      if (kind != 2'd3 && sensor < NSENS) begin
         k = sensor * 3 + kind;
         dv = $signed(value) - $signed(last_value[k]);
         dt = longint'(stamp) - longint'(last_stamp[k]);
         o.raised = rate_exceeded(kind, dv, dt);
         last_value[k] = value;
         last_stamp[k] = stamp;
         if (o.raised) begin
            if (ring_count >= NINC) begin
               ring_head = ring_slot(1);
               ring_count = NINC - 1;
            end
            s = ring_slot(ring_count);
            ring_sensor[s] = sensor;
            ring_kind[s] = kind;
            ring_stamp[s] = stamp;
            ring_count++;
            // Drop leading incidents that are too old relative to the newest one.
            if (ring_count > 1) begin
               nw = ring_slot(ring_count - 1);
               drop = ring_count - 1;
               for (int p = 0; p + 1 < ring_count; p++) begin
                  age = longint'(ring_stamp[nw]) - longint'(ring_stamp[ring_slot(p)]);
                  if (age < longint'(window_ticks)) begin
                     drop = p;
                     break;
                  end
               end
               ring_head = ring_slot(drop);
               ring_count -= drop;
            end
            // Neighbour search against the newest incident.
            hit = 0;
            if (ring_count > 1) begin
               nw = ring_slot(ring_count - 1);
               for (int p = 0; p < ring_count; p++) begin
                  s = ring_slot(p);
                  if (nbr_map[ring_sensor[nw] * 8 + ring_sensor[s]] &&
                      ring_kind[s] != ring_kind[nw] &&
                      (!press_required || ring_kind[s] == KIND_PRESSURE ||
                       ring_kind[nw] == KIND_PRESSURE))
                     hit = 1;
               end
            end
            o.found = hit;
            if (hit) held_detection = stamp;
         end
      end
      o.dtime = held_detection;
      return o;
   endfunction

   // Sends one sample beat and records its expected response on acceptance.
   task automatic send_sample(bit [2:0] sensor, bit [1:0] kind, bit [15:0] value,
                              bit [31:0] stamp);
      outcome_type want;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, stamp, value, sensor};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      want = predict_response(sensor, kind, value, stamp);
      pending_q = {pending_q, want};
      @(negedge clock);
      // Bursts: sometimes drop valid for a random gap.
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic write_reg(bit [7:0] index, bit [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_TEMPERATURE_LIMIT: lim_temp = value[23:0];
         REG_VOLTAGE_LIMIT:     lim_volt = value[23:0];
         REG_PRESSURE_LIMIT:    lim_press = value[23:0];
         REG_RELATED_WINDOW:    window_ticks = value[31:0];
         REG_NEIGHBOUR_MAP:     nbr_map = value;
         REG_PRESSURE_PRESENT:  press_required = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Lowers valid, waits for every outstanding response and then for the
   // longest prune walk, so that the block is idle before a register write.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(negedge clock);
      repeat (NINC + 12) @(negedge clock);
   endtask

   task automatic set_all(bit [23:0] t, bit [23:0] v, bit [23:0] p, bit [31:0] w,
                          bit [63:0] m, bit pr);
      drain();
      write_reg(REG_TEMPERATURE_LIMIT, t);
      write_reg(REG_VOLTAGE_LIMIT, v);
      write_reg(REG_PRESSURE_LIMIT, p);
      write_reg(REG_RELATED_WINDOW, w);
      write_reg(REG_NEIGHBOUR_MAP, m);
      write_reg(REG_PRESSURE_PRESENT, pr);
   endtask

   // Field extremes, an invalid kind, zero and negative dt, and a
   // simple propagation pair of two kinds on one sensor.
   task automatic test_directed;
      set_all(24'd256, 24'd256, 24'd256, 32'd1000, 64'h0000_0000_0000_0201, 1'b0);
      send_sample(3'd0, KIND_TEMPERATURE, 16'h7FFF, 32'd10);
      send_sample(3'd0, KIND_TEMPERATURE, 16'h8000, 32'd11);
      send_sample(3'd1, KIND_VOLTAGE, 16'h8000, 32'd12);
      send_sample(3'd1, KIND_VOLTAGE, 16'h8000, 32'd12);
      send_sample(3'd0, KIND_VOLTAGE, 16'h0100, 32'd13);
      send_sample(3'd0, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
      send_sample(3'd7, KIND_PRESSURE, 16'hFFFF, 32'hFFFF_FFFF);
      send_sample(3'd7, KIND_PRESSURE, 16'h0000, 32'd0);
      send_sample(3'd1, KIND_PRESSURE, 16'h0001, 32'd14);
      send_sample(3'd0, KIND_PRESSURE, 16'h1234, 32'd15);
      send_sample(3'd0, KIND_TEMPERATURE, 16'h7FFF, 32'd14);
      // Zero limits: every temperature sample crosses, even with dt = 0.
      set_all(24'd0, 24'd0, 24'hFFFFFF, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_sample(3'd2, KIND_TEMPERATURE, 16'd5, 32'd100);
      send_sample(3'd3, KIND_VOLTAGE, 16'd9, 32'd101);
      send_sample(3'd3, KIND_TEMPERATURE, 16'd9, 32'd101);
      send_sample(3'd4, KIND_PRESSURE, 16'h8000, 32'd102);
      send_sample(3'd4, KIND_PRESSURE, 16'h7FFF, 32'd103);
      set_all(24'd0, 24'd0, 24'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      for (int i = 0; i < 8; i++)
         send_sample(3'(i), 2'(i % 3), 16'(i * 37), 32'd200 + i);
   endtask

   // Random samples, mostly close in time so incidents cluster and the
   // window fills and wraps; the limits and maps change between phases.
   task automatic test_random(int count);
      bit [31:0] base;
      for (int phase = 0; phase < 6; phase++) begin
         set_all($urandom_range(0, 3) == 0 ? 24'hFFFFFF : 24'($urandom_range(0, 2048)),
                 24'($urandom_range(0, 2048)), 24'($urandom_range(0, 2048)),
                 phase == 5 ? 32'hFFFF_FFFF : 32'($urandom_range(0, 300)),
                 {$urandom, $urandom}, 1'($urandom));
         base = $urandom;
         for (int i = 0; i < count / 6; i++) begin
            base += $urandom_range(0, 20);
            send_sample(3'($urandom), $urandom_range(0, 19) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
                        16'($urandom),
                        $urandom_range(0, 15) == 0 ? $urandom : base);
         end
      end
   endtask

   // The receiver stops for a long stretch while samples keep coming.
   task automatic test_backpressure;
      drain();
      rand_stall = 1'b0;
      hold_off = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 20; i++)
            send_sample(3'($urandom), 2'($urandom_range(0, 2)), 16'($urandom), 32'(i * 3));
      join
      rand_stall = 1'b1;
   endtask

   // Receiver ready: its own stall pattern, with stall-free stretches.
   always @(negedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else if (!rand_stall || clock_ticks[9]) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 2) != 0);
   end

   // Checks each response beat against the oldest prediction.
   always @(posedge clock) begin
      outcome_type want;
      clock_ticks <= clock_ticks + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            $error("response beat with no prediction waiting");
            error_count++;
         end else begin
            want = pending_q.pop_front();
            if (rsp_tdata[0] !== want.raised) begin
               $error("incident_raised: expected %0d, got %0d", want.raised, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[1] !== want.found) begin
               $error("propagation_found: expected %0d, got %0d", want.found, rsp_tdata[1]);
               error_count++;
            end
            if (rsp_tdata[33:2] !== want.dtime) begin
               $error("detection_time: expected %0d, got %0d", want.dtime, rsp_tdata[33:2]);
               error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      clock_ticks = 0;
      lim_temp = 256; lim_volt = 256; lim_press = 256;
      window_ticks = 1000; nbr_map = 0; press_required = 0;
      foreach (last_value[i]) begin
         last_value[i] = 0;
         last_stamp[i] = 0;
      end
      ring_count = 0; ring_head = 0; held_detection = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(580);
      test_backpressure();
      drain();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
